// ----- rtl/lzw_code_decoder_unit_macros.svh -----
// Assertion helpers used by the decoder back end (lzwd_back).
`ifndef LZW_CODE_DECODER_UNIT_MACROS_SVH
`define LZW_CODE_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define LZWD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzwd assertion failed");
// Next-cycle implication, disabled while in reset
`define LZWD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lzwd assertion failed");
`else
`define LZWD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LZWD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/lzwd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

  localparam int CODE_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int NUM_BYTES = 256;

  // Classified code as it waits between front and back
  typedef struct packed {
    logic              start;
    logic              zero;
    logic [CODE_W-1:0] entry;
  } q_item_t;

  // Back-end sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_LEN   = 8'b0000_0100,
    ST_WALK  = 8'b0000_1000,
    ST_KFIX  = 8'b0001_0000,
    ST_UPD   = 8'b0010_0000,
    ST_EMIT  = 8'b0100_0000,
    ST_ERR   = 8'b1000_0000
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/lzwd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/lzwd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lzwd_front
  import lzwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CODE_W-1:0] in_code,
  input  wire logic              in_start,
  output logic                   q_valid,
  output q_item_t                q_head,
  input  wire logic              q_pop
);

  q_item_t    q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_item_t    item;

  // Classify: zero code flag and zero-based entry index
  always_comb begin
    item.start = in_start;
    item.zero  = (in_code == '0);
    item.entry = in_code - CODE_W'(1);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rd_ptr_r];

  // Two-entry queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lzwd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_code_decoder_unit_macros.svh"

module lzwd_back
  import lzwd_pkg::*;
#(
  parameter int DICT_ENTRIES = 4096,
  parameter int MAX_LEN      = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire q_item_t           q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] out_byte,
  output logic                   out_last,
  output logic                   out_err
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int CW = $clog2(DICT_ENTRIES + 1);
  localparam int LW = $clog2(MAX_LEN + 2);
  localparam int KW = $clog2(MAX_LEN);
  localparam int DW = AW + BYTE_W + LW;

  back_state_t       state_r, state_nxt;
  logic [CW-1:0]     ent_cnt_r, ent_cnt_nxt;
  logic [AW-1:0]     prev_r, prev_nxt;
  logic [LW-1:0]     prev_len_r, prev_len_nxt;
  logic              have_r, have_nxt;
  logic              start_r, start_nxt;
  logic              zero_r, zero_nxt;
  logic [CODE_W-1:0] e_r, e_nxt;
  logic              kwk_r, kwk_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     idx_r, idx_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  logic              dict_we;
  logic [DW-1:0]     dict_wdata, dict_rdata;
  logic [AW-1:0]     rd_prefix;
  logic [BYTE_W-1:0] rd_suffix;
  logic [LW-1:0]     rd_len, len_now, new_len;
  logic              stk_we;
  logic [KW-1:0]     stk_waddr;
  logic [BYTE_W-1:0] stk_wdata, stk_rdata, walk_byte;
  logic              cur_is_byte, out_free, e_below, e_next;

  // Dictionary: prefix, suffix, length packed in one word
  lzwd_ram #(.WIDTH(DW), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (ent_cnt_r[AW-1:0]),
    .wdata (dict_wdata),
    .raddr (cur_nxt),
    .rdata (dict_rdata)
  );

  // String is built back to front here, then read out in order
  lzwd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (idx_nxt),
    .rdata (stk_rdata)
  );

  assign rd_len    = dict_rdata[LW-1:0];
  assign rd_suffix = dict_rdata[LW+BYTE_W-1:LW];
  assign rd_prefix = dict_rdata[DW-1:LW+BYTE_W];

  assign cur_is_byte = (cur_r < AW'(NUM_BYTES));
  assign walk_byte   = cur_is_byte ? cur_r[BYTE_W-1:0] : rd_suffix;
  assign len_now     = cur_is_byte ? LW'(1) : rd_len;
  assign out_free    = !out_v_r || out_ready;
  assign e_below     = (e_r < CODE_W'(ent_cnt_r));
  assign e_next      = (e_r == CODE_W'(ent_cnt_r)) && have_r &&
                       (ent_cnt_r < CW'(DICT_ENTRIES));
  assign new_len     = (prev_len_r > LW'(MAX_LEN)) ? LW'(MAX_LEN + 1)
                                                   : prev_len_r + LW'(1);
  assign dict_wdata  = {prev_r, first_r, new_len};

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    ent_cnt_nxt  = ent_cnt_r;
    prev_nxt     = prev_r;
    prev_len_nxt = prev_len_r;
    have_nxt     = have_r;
    start_nxt    = start_r;
    zero_nxt     = zero_r;
    e_nxt        = e_r;
    kwk_nxt      = kwk_r;
    cur_nxt      = cur_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    first_nxt    = first_r;
    out_v_nxt    = out_ready ? 1'b0 : out_v_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    q_pop        = 1'b0;
    dict_we      = 1'b0;
    stk_we       = 1'b0;
    stk_waddr    = k_r;
    stk_wdata    = walk_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          start_nxt = q_head.start;
          zero_nxt  = q_head.zero;
          e_nxt     = q_head.entry;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // restart takes effect before the code is judged
        if (start_r) begin
          ent_cnt_nxt  = CW'(NUM_BYTES);
          prev_nxt     = '0;
          prev_len_nxt = LW'(1);
          have_nxt     = 1'b0;
          start_nxt    = 1'b0;
        end else if (zero_r) begin
          state_nxt = ST_ERR;
        end else if (e_below) begin
          kwk_nxt   = 1'b0;
          cur_nxt   = e_r[AW-1:0];
          state_nxt = ST_LEN;
        end else if (e_next && (prev_len_r < LW'(MAX_LEN))) begin
          // KwKwK: previous string plus its own first byte
          kwk_nxt   = 1'b1;
          cur_nxt   = prev_r;
          n_nxt     = prev_len_r + LW'(1);
          k_nxt     = KW'(prev_len_r - LW'(1));
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_ERR;
        end
      end
      ST_LEN: begin
        if ((len_now == '0) || (len_now > LW'(MAX_LEN))) begin
          state_nxt = ST_ERR;
        end else begin
          n_nxt     = len_now;
          k_nxt     = KW'(len_now - LW'(1));
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // one chain link per cycle, last byte first
        stk_we  = 1'b1;
        cur_nxt = cur_is_byte ? '0 : rd_prefix;
        if (k_r == '0) begin
          first_nxt = walk_byte;
          state_nxt = kwk_r ? ST_KFIX : ST_UPD;
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end
      ST_KFIX: begin
        stk_we    = 1'b1;
        stk_waddr = KW'(n_r - LW'(1));
        stk_wdata = first_r;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (have_r && (ent_cnt_r < CW'(DICT_ENTRIES))) begin
          dict_we     = 1'b1;
          ent_cnt_nxt = ent_cnt_r + CW'(1);
        end
        prev_nxt     = e_r[AW-1:0];
        prev_len_nxt = n_r;
        have_nxt     = 1'b1;
        idx_nxt      = '0;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_byte_nxt = stk_rdata;
          out_err_nxt  = 1'b0;
          out_last_nxt = (LW'(idx_r) == n_r - LW'(1));
          if (LW'(idx_r) == n_r - LW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + KW'(1);
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_byte_nxt = '0;
          out_last_nxt = 1'b1;
          out_err_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ent_cnt_r  <= CW'(NUM_BYTES);
      prev_r     <= '0;
      prev_len_r <= LW'(1);
      have_r     <= 1'b0;
      start_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ent_cnt_r  <= ent_cnt_nxt;
      prev_r     <= prev_nxt;
      prev_len_r <= prev_len_nxt;
      have_r     <= have_nxt;
      start_r    <= start_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    zero_r     <= zero_nxt;
    e_r        <= e_nxt;
    kwk_r      <= kwk_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    first_r    <= first_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid = out_v_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

  // Checks
  `LZWD_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_r == ST_IDLE)
  `LZWD_ASSERT_NXT(a_cnt_step, clk, rst_n, dict_we, ent_cnt_r == $past(ent_cnt_r) + CW'(1))
  `LZWD_ASSERT_IMP(a_emit_idx, clk, rst_n, state_r == ST_EMIT, LW'(idx_r) < n_r)
  `LZWD_ASSERT_NXT(a_upd_have, clk, rst_n, state_r == ST_UPD, have_r && (state_r == ST_EMIT))

endmodule

`default_nettype wire

// ----- rtl/lzw_code_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// LZW code decoder.
// Input channel in_*: one 16-bit one-based code per transaction in in_tdata,
// in_tuser set on the first code of a stream (dictionary restarts at 256).
// Output channel out_*: one decoded byte per transaction, out_tlast on the
// final byte of a code, out_tuser flags a rejected code (zero, out of range
// or longer than MAX_LEN); that code gives a single transaction with data 0.
// A two-entry queue takes codes while the decode engine is busy.
// Per code the engine takes the code, classifies it and looks up the length,
// walks the prefix chain in the dictionary RAM (one read per link), appends
// the new entry and reads the string out of the stack RAM. A KwKwK code skips
// the length lookup, walks one link fewer than its length and patches its
// last byte. A restart resets the dictionary before the code is judged.
// Reset empties the queue and output register and restarts the dictionary
// at 256 entries; the dictionary RAM is not cleared (no clearing pass).
// When the receiver stalls the output register holds its byte, the engine
// waits, and the queue fills and then drops in_tready.
module lzw_code_decoder_unit
  import lzwd_pkg::*;
#(
  parameter int DICT_ENTRIES = 4096,
  parameter int MAX_LEN      = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [15:0] code_word
  input  wire logic        in_tuser,  // [0] stream_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata, // [7:0] data_byte
  output logic             out_tlast,
  output logic             out_tuser  // [0] code_error
);

  logic    q_valid;
  q_item_t q_head;
  logic    q_pop;

  // Accept and classify, queue
  lzwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_code  (in_tdata),
    .in_start (in_tuser),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Decode engine
  lzwd_back #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .MAX_LEN      (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_err   (out_tuser)
  );

endmodule

`default_nettype wire

// ----- sim/tb_lzw_code_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_lzw_code_decoder_unit;

  localparam int DICT_ENTRIES = 4096;
  localparam int MAX_LEN      = 64;
  localparam int FIRST_FREE   = 256;
  localparam int RAND_CODES   = 64;
  localparam int TAIL_CYCLES  = 2 * MAX_LEN + 40;
  localparam int MAX_REPORTS  = 20;

  // One code waiting to be sent
  typedef struct packed {
    logic [15:0] code;
    logic        start;
  } code_item_t;

  // One decoded byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } byte_result_t;

  // Receiver ready patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SLOW,
    RX_BEAT
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  lzw_code_decoder_unit #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] code_word
    .in_tuser  (in_tuser),   // [0] stream_start
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] data_byte
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)   // [0] code_error
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dictionary copy kept by the predictor
  bit [15:0]   link_tab [0:DICT_ENTRIES-1];
  bit [7:0]    tail_tab [0:DICT_ENTRIES-1];
  bit [6:0]    size_tab [0:DICT_ENTRIES-1];
  bit [7:0]    str_buf  [0:MAX_LEN];
  int unsigned dict_count = FIRST_FREE;
  int unsigned last_entry = 0;
  bit          have_last  = 1'b0;

  code_item_t   code_queue [$];
  byte_result_t exp_bytes  [$];

  int n_fail    = 0;
  int n_codes   = 0;
  int n_bytes   = 0;
  int n_rejects = 0;
  int n_kwk     = 0;
  int max_str   = 0;

  function automatic int unsigned entry_len(int unsigned e);
    if (e < FIRST_FREE) return 1;
    if (e >= DICT_ENTRIES) return 0;
    return size_tab[e];
  endfunction

  // Decode one accepted code: update the dictionary, queue the bytes it yields
  task automatic decode_code(input logic [15:0] code, input logic start);
    int unsigned e, n, len, cur, k, nl;
    bit kwk, bad;
    e   = 0;
    n   = 0;
    kwk = 1'b0;
    if (start) begin
      dict_count = FIRST_FREE;
      last_entry = 0;
      have_last  = 1'b0;
    end
    n_codes++;
    bad = (code == 16'd0);
    if (!bad) begin
      e = code;
      e = e - 1;
      if (e < dict_count) begin
        n = entry_len(e);
      end else if (e == dict_count && have_last && dict_count < DICT_ENTRIES) begin
        kwk = 1'b1;
        n   = entry_len(last_entry) + 1;
      end else begin
        bad = 1'b1;
      end
    end
    if (!bad && (n == 0 || n > MAX_LEN)) bad = 1'b1;
    if (bad) begin
      exp_bytes.push_back('{8'd0, 1'b1, 1'b1});
      n_rejects++;
      return;
    end
    // walk the prefix chain backwards into the string buffer
    cur = kwk ? last_entry : e;
    len = kwk ? n - 1 : n;
    for (k = len; k > 0; k--) begin
      if (cur < FIRST_FREE) begin
        str_buf[k-1] = cur[7:0];
        cur = 0;
      end else begin
        str_buf[k-1] = tail_tab[cur];
        cur = link_tab[cur];
      end
    end
    if (kwk) begin
      str_buf[n-1] = str_buf[0];
      n_kwk++;
    end
    // append previous string plus first byte; over-long entries saturate
    if (have_last && dict_count < DICT_ENTRIES) begin
      nl = entry_len(last_entry) + 1;
      if (nl > MAX_LEN + 1) nl = MAX_LEN + 1;
      link_tab[dict_count] = last_entry[15:0];
      tail_tab[dict_count] = str_buf[0];
      size_tab[dict_count] = nl[6:0];
      dict_count++;
    end
    last_entry = e;
    have_last  = 1'b1;
    if (n > max_str) max_str = n;
    for (k = 0; k < n; k++) begin
      exp_bytes.push_back('{str_buf[k], (k + 1 == n), 1'b0});
    end
  endtask

  task automatic push_code(input logic [15:0] code, input logic start);
    code_queue.push_back('{code, start});
  endtask

  // Block until everything sent has been decoded and checked
  task automatic wait_drained();
    while (code_queue.size() != 0 || in_tvalid || exp_bytes.size() != 0)
      @(negedge clk);
  endtask

  // Valid codes only: known entries, single bytes and KwKwK codes
  task automatic well_formed_run(input int codes, input bit restart);
    int unsigned cnt, base, plen, e, n, pick;
    bit hp;
    int i;
    cnt  = restart ? FIRST_FREE : dict_count;
    hp   = restart ? 1'b0 : have_last;
    plen = hp ? entry_len(last_entry) : 0;
    base = cnt;
    for (i = 0; i < codes; i++) begin
      pick = $urandom_range(0, 9);
      if (hp && cnt < DICT_ENTRIES && plen < MAX_LEN && pick < 3) begin
        e = cnt;
        n = plen + 1;
      end else if (base > FIRST_FREE && pick < 7) begin
        e = $urandom_range(FIRST_FREE, base - 1);
        n = entry_len(e);
        if (n > MAX_LEN) begin
          e = $urandom_range(0, 255);
          n = 1;
        end
      end else begin
        e = $urandom_range(0, 255);
        n = 1;
      end
      push_code(16'(e + 1), restart && i == 0);
      if (hp && cnt < DICT_ENTRIES) cnt++;
      hp   = 1'b1;
      plen = n;
    end
  endtask

  // Broken codes: zero, out of range, anything, restarts
  task automatic noise_codes(input int count);
    int i;
    logic [15:0] code;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       code = 16'd0;
        1:       code = 16'($urandom_range(dict_count + 2, 65535));
        2:       code = 16'($urandom_range(1, dict_count));
        default: code = 16'($urandom_range(0, 65535));
      endcase
      push_code(code, $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic random_phase(inout int sent);
    int codes, junk;
    bit restart;
    codes   = $urandom_range(4, 16);
    junk    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 2);
    restart = ($urandom_range(0, 5) == 0) || !have_last;
    well_formed_run(codes, restart);
    noise_codes(junk);
    sent += codes + junk;
    wait_drained();
  endtask

  // Sender: bursts of random length with random gaps
  code_item_t drv_item;
  int         burst_left = 0;
  int         gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (burst_left != 0 && code_queue.size() != 0) begin
        drv_item = code_queue.pop_front();
        in_tvalid  <= 1'b1;
        in_tdata   <= drv_item.code;
        in_tuser   <= drv_item.start;
        burst_left <= burst_left - 1;
      end else begin
        in_tvalid <= 1'b0;
        if (burst_left == 0) begin
          if (gap_left != 0) begin
            gap_left <= gap_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: a randomly chosen ready pattern, re-chosen when its run ends
  rx_mode_t rx_mode   = RX_FREE;
  int       mode_left = 0;
  int       beat_cnt  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      mode_left  <= 0;
      beat_cnt   <= 0;
    end else begin
      beat_cnt <= beat_cnt + 1;
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE: out_tready <= 1'b1;
        RX_COIN: out_tready <= ($urandom_range(0, 1) == 1);
        RX_SLOW: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (beat_cnt % 3) != 0;
      endcase
    end
  end

  // Monitor: predict on input transactions, check output transactions
  byte_result_t got, want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_code(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tlast, out_tuser};
        if (exp_bytes.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected byte data=%02h last=%0b err=%0b",
                     $time, got.data, got.last, got.err);
        end else begin
          want = exp_bytes.pop_front();
          n_bytes++;
          if (got.data !== want.data || got.last !== want.last || got.err !== want.err) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display({"%0t: mismatch expected data=%02h last=%0b err=%0b,",
                        " actual data=%02h last=%0b err=%0b"},
                       $time, want.data, want.last, want.err,
                       got.data, got.last, got.err);
          end
        end
      end
    end
  end

  // Stimulus
  int sent = 0;
  int j;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, table codes, KwKwK, each kind of reject
    push_code(16'd1, 1'b1);      // byte 0, first code of stream
    push_code(16'd256, 1'b0);    // byte 255
    push_code(16'd257, 1'b0);    // first table entry
    push_code(16'd259, 1'b0);    // KwKwK
    push_code(16'd0, 1'b0);      // zero code
    push_code(16'd65535, 1'b0);  // far out of range
    push_code(16'd261, 1'b0);    // one past the next entry
    push_code(16'd0, 1'b1);      // restart then zero code
    push_code(16'd257, 1'b0);    // next entry with no previous code
    push_code(16'd129, 1'b0);
    push_code(16'd257, 1'b0);    // KwKwK on a single byte
    push_code(16'd256, 1'b1);
    push_code(16'h8000, 1'b0);
    push_code(16'd128, 1'b0);
    push_code(16'd258, 1'b0);
    push_code(16'd65535, 1'b1);  // restart with an invalid code
    push_code(16'd171, 1'b0);
    wait_drained();

    // chain of KwKwK codes up to the longest legal string, then past it
    push_code(16'd66, 1'b1);
    for (j = 0; j < MAX_LEN - 1; j++) push_code(16'(257 + j), 1'b0);
    push_code(16'd320, 1'b0);    // would be one byte too long
    push_code(16'd319, 1'b0);    // longest legal string
    push_code(16'd66, 1'b0);     // appends an over-long entry
    push_code(16'd320, 1'b0);    // names the over-long entry
    wait_drained();

    while (sent < RAND_CODES) random_phase(sent);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_bytes.size() != 0) begin
      n_fail++;
      $display("%0t: %0d expected bytes never arrived", $time, exp_bytes.size());
    end
    $display("Decoded %0d codes (%0d KwKwK, %0d rejected) into %0d checked bytes;",
             n_codes, n_kwk, n_rejects, n_bytes);
    $display("longest string %0d bytes, %0d failures", max_str, n_fail);
    if (n_fail == 0) begin
      $display("tb_lzw_code_decoder_unit passed");
    end else begin
      $display("tb_lzw_code_decoder_unit failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb_lzw_code_decoder_unit failed");
    $finish;
  end

endmodule
